>>> rtl/core/lmpa_pkg.sv
// Shared types and constants of the level meter.
`default_nettype none
package lmpa_pkg;

  localparam int LEVEL_W = 16;
  localparam int DB_W    = 17;
  localparam int PEAK_W  = 16;
  localparam int REG_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WINDOW = 2'd1;
  localparam logic [REG_W-1:0]     REG_WINDOW_RESET   = 4'd10;
  localparam int                   DFLT_WINDOW        = 5;

  localparam logic signed [DB_W-1:0] DB_ZERO_LEVEL = -17'sd46080;
  localparam logic signed [DB_W-1:0] PEAK_FLOOR    = -17'sd25600;

  // log2 datapath
  localparam int MANT_W   = 31;          // Q.30 mantissa in [1,2)
  localparam int SQ_W     = 2 * MANT_W;
  localparam int FRAC_W   = 16;
  localparam int EXP_W    = 4;
  localparam int A_W      = 21;          // 16.0 - log2 in Q.16, up to 2^20
  localparam int PROD_W   = 40;
  localparam int RND_SHIFT = 24;
  localparam int DBMAG_W  = PROD_W - RND_SHIFT;
  localparam logic [18:0] DB_PER_OCTAVE_Q16 = 19'd394566;

  // divider
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(DB_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_SHIFT,
    ST_WAIT,
    ST_FINISH,
    ST_REFILL
  } lmpa_state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_SQUARE,
    LG_SCALE,
    LG_ROUND
  } lmpa_log_state_t;

  typedef struct packed {
    logic                   peak_shift;
    logic                   peak_fill;
    logic                   avg_shift;
    logic                   avg_fill;
    logic signed [DB_W-1:0] peak_data;
    logic signed [DB_W-1:0] avg_data;
  } lmpa_cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/lmpa_if.sv
// Sample and result channel interfaces of the level meter.
`default_nettype none
interface lmpa_in_if;
  logic                              valid;
  logic                              ready;
  logic [lmpa_pkg::LEVEL_W-1:0]      level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface lmpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lmpa_pkg::DB_W-1:0]  average_db;
  logic signed [lmpa_pkg::PEAK_W-1:0] peak_db;

  modport source (output valid, output average_db, output peak_db, input ready);
  modport sink   (input valid, input average_db, input peak_db, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lmpa_log.sv
// Linear level to Q.8 dB converter: log2 by repeated squaring, then scaling.
`default_nettype none
module lmpa_log (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [lmpa_pkg::LEVEL_W-1:0]        level,
  output logic                                     busy,
  output logic                                     done,
  output logic signed [lmpa_pkg::DB_W-1:0]         db
);

  lmpa_pkg::lmpa_log_state_t state, state_next;

  logic [lmpa_pkg::MANT_W-1:0]  m;
  logic [lmpa_pkg::FRAC_W-1:0]  frac;
  logic [lmpa_pkg::EXP_W-1:0]   expo;
  logic                         zero;
  logic [3:0]                   cnt;
  logic [lmpa_pkg::PROD_W-1:0]  scaled;

  logic [lmpa_pkg::EXP_W-1:0]   msb;
  logic [4:0]                   shamt;
  logic [lmpa_pkg::MANT_W-1:0]  m_init;
  logic [lmpa_pkg::SQ_W-1:0]    sq_full;
  logic [lmpa_pkg::MANT_W:0]    sq;
  logic [lmpa_pkg::A_W-1:0]     a_val;
  logic [lmpa_pkg::PROD_W-1:0]  scale_prod;
  logic [lmpa_pkg::PROD_W-1:0]  rnd;
  logic [lmpa_pkg::DBMAG_W-1:0] mag;

  // leading one; a zero sample leaves msb at 0 and is patched at the end
  always_comb begin
    msb = '0;
    for (int i = 0; i < lmpa_pkg::LEVEL_W; i++) begin
      if (level[i]) msb = lmpa_pkg::EXP_W'(i);
    end
  end

  assign shamt  = 5'd30 - 5'(msb);
  assign m_init = {15'b0, level} << shamt;

  assign sq_full    = lmpa_pkg::SQ_W'(m) * lmpa_pkg::SQ_W'(m);
  assign sq         = sq_full[lmpa_pkg::SQ_W-1:30];
  assign a_val      = 21'h100000 - {1'b0, expo, frac};
  assign scale_prod = lmpa_pkg::PROD_W'(a_val) * lmpa_pkg::PROD_W'(lmpa_pkg::DB_PER_OCTAVE_Q16);
  assign rnd        = scaled + (lmpa_pkg::PROD_W'(1) << (lmpa_pkg::RND_SHIFT - 1));
  assign mag        = rnd[lmpa_pkg::PROD_W-1:lmpa_pkg::RND_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmpa_pkg::LG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lmpa_pkg::LG_IDLE:   if (start) state_next = lmpa_pkg::LG_SQUARE;
      lmpa_pkg::LG_SQUARE: if (cnt == 4'd0) state_next = lmpa_pkg::LG_SCALE;
      lmpa_pkg::LG_SCALE:  state_next = lmpa_pkg::LG_ROUND;
      lmpa_pkg::LG_ROUND:  state_next = lmpa_pkg::LG_IDLE;
      default:             state_next = lmpa_pkg::LG_IDLE;
    endcase
  end

  assign busy = (state != lmpa_pkg::LG_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == lmpa_pkg::LG_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lmpa_pkg::LG_IDLE: begin
        if (start) begin
          m    <= m_init;
          expo <= msb;
          zero <= (level == '0);
          frac <= '0;
          cnt  <= 4'd15;
        end
      end
      lmpa_pkg::LG_SQUARE: begin
        // square overflowing 2.0 yields a one bit and renormalises
        if (sq[lmpa_pkg::MANT_W]) begin
          m <= sq[lmpa_pkg::MANT_W:1];
        end else begin
          m <= sq[lmpa_pkg::MANT_W-1:0];
        end
        frac <= {frac[lmpa_pkg::FRAC_W-2:0], sq[lmpa_pkg::MANT_W]};
        cnt  <= cnt - 4'd1;
      end
      lmpa_pkg::LG_SCALE: begin
        scaled <= scale_prod;
      end
      lmpa_pkg::LG_ROUND: begin
        db <= zero ? lmpa_pkg::DB_ZERO_LEVEL : -$signed({1'b0, mag});
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/lmpa_div.sv
// Bit-serial signed divider by a small window length, truncating toward zero.
`default_nettype none
module lmpa_div #(
  parameter int D_W = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [lmpa_pkg::DB_W-1:0]   dividend,
  input  wire logic [D_W-1:0]                     divisor,
  output logic                                    busy,
  output logic signed [lmpa_pkg::DB_W-1:0]        quotient
);

  logic [lmpa_pkg::DB_W-1:0]      mag;
  logic [D_W-1:0]                 rem;
  logic [D_W-1:0]                 dq;
  logic                           neg;
  logic [lmpa_pkg::DIV_CNT_W-1:0] cnt;

  logic [D_W:0] trial;
  logic [D_W:0] diff;
  logic         ge;

  assign trial = {rem, mag[lmpa_pkg::DB_W-1]};
  assign ge    = (trial >= {1'b0, dq});
  assign diff  = trial - {1'b0, dq};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[lmpa_pkg::DB_W-1];
      mag <= dividend[lmpa_pkg::DB_W-1] ? lmpa_pkg::DB_W'(-dividend)
                                          : lmpa_pkg::DB_W'(dividend);
      rem <= '0;
      dq  <= divisor;
      cnt <= lmpa_pkg::DIV_LAST_STEP;
    end else if (busy) begin
      // quotient bits shift in where dividend bits leave
      rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      mag <= {mag[lmpa_pkg::DB_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire

>>> rtl/core/lmpa_cell.sv
// One window slot: peak and average history entries plus one stage of the max chain.
`default_nettype none
module lmpa_cell #(
  parameter int N_W = 4,
  parameter int POS = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lmpa_pkg::lmpa_cell_cmd_t           cmd,
  input  wire logic [N_W-1:0]                     peak_n,
  input  wire logic [N_W-1:0]                     avg_n,
  input  wire logic signed [lmpa_pkg::DB_W-1:0]   peak_up,
  input  wire logic signed [lmpa_pkg::DB_W-1:0]   avg_up,
  input  wire logic signed [lmpa_pkg::DB_W-1:0]   max_up,
  output logic signed [lmpa_pkg::DB_W-1:0]        peak,
  output logic signed [lmpa_pkg::DB_W-1:0]        avg,
  output logic signed [lmpa_pkg::DB_W-1:0]        max_out
);

  localparam logic [N_W-1:0] HERE = N_W'(POS);
  localparam logic [N_W-1:0] NEXT = N_W'(POS + 1);

  logic p_in, p_mid, p_last;
  logic a_in, a_mid, a_last;

  assign p_in   = (HERE < peak_n);
  assign p_mid  = (NEXT < peak_n);
  assign p_last = (NEXT == peak_n);
  assign a_in   = (HERE < avg_n);
  assign a_mid  = (NEXT < avg_n);
  assign a_last = (NEXT == avg_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      avg     <= '0;
      max_out <= lmpa_pkg::PEAK_FLOOR;
    end else begin
      if (cmd.peak_fill && p_in) begin
        peak <= cmd.peak_data;
      end else if (cmd.peak_shift) begin
        if (p_mid) begin
          peak <= peak_up;
        end else if (p_last) begin
          peak <= cmd.peak_data;
        end
      end

      if (cmd.avg_fill && a_in) begin
        avg <= cmd.avg_data;
      end else if (cmd.avg_shift) begin
        if (a_mid) begin
          avg <= avg_up;
        end else if (a_last) begin
          avg <= cmd.avg_data;
        end
      end

      // slots outside the window drop out of the max
      max_out <= (p_in && peak > max_up) ? peak : max_up;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/level_meter_peak_average_top.sv
// Level meter top level: sequencer, window cells, dB converter and divider.
//
// Each level word is converted to dB in signed Q.8 (20*log10(level/65536), a
// zero word reads as -180 dB) and pushed into a peak-hold window and a moving
// average window, each held in a row of WINDOW_DEPTH cells. Every word gives
// one result word: the running average and the window peak, floored at
// -100 dB. For each word the log2 runs as 16 squarings on one 31x31
// multiplier, the per-entry share dB/n comes from a one-bit-per-cycle
// divider, and the window maximum ripples down the cell chain one cell per
// cycle. Items are taken one at a time; a new word is accepted while the
// previous result still waits at the output register. Window lengths of 0
// or above WINDOW_DEPTH act as 5 (or WINDOW_DEPTH if smaller). Writing
// peak_window refills that window from the current peak in the next cycle;
// writing average_window in the idle state, with no word taken in that
// cycle, refills it with running_sum/n; no word is accepted until it is done.
`default_nettype none
module level_meter_peak_average_top #(
  parameter int WINDOW_DEPTH = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  lmpa_in_if.sink                                   samples,
  lmpa_out_if.source                                levels,
  input  wire logic                                 cfg_write,
  input  wire logic [lmpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lmpa_pkg::REG_W-1:0]           cfg_data
);

  localparam int DB_W  = lmpa_pkg::DB_W;
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (N_W > lmpa_pkg::REG_W) ? N_W : lmpa_pkg::REG_W;
  localparam int DFLT  = (WINDOW_DEPTH < lmpa_pkg::DFLT_WINDOW) ? WINDOW_DEPTH
                                                                 : lmpa_pkg::DFLT_WINDOW;

  function automatic logic [N_W-1:0] eff_window(input logic [lmpa_pkg::REG_W-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r >= CMP_W'(1) && r <= CMP_W'(WINDOW_DEPTH)) begin
      return N_W'(r);
    end
    return N_W'(DFLT);
  endfunction

  lmpa_pkg::lmpa_state_t   state, state_next;
  lmpa_pkg::lmpa_cell_cmd_t cmd;

  logic [lmpa_pkg::REG_W-1:0]      peak_window;
  logic [lmpa_pkg::REG_W-1:0]      average_window;
  logic signed [lmpa_pkg::PEAK_W-1:0] peak_level;
  logic signed [DB_W-1:0]          running_sum;
  logic signed [DB_W-1:0]          running_sum_next;
  logic [N_W-1:0]                  cnt;
  logic                            pfill_pend;

  logic                            out_valid;
  logic signed [DB_W-1:0]          out_avg;
  logic signed [lmpa_pkg::PEAK_W-1:0] out_peak;
  logic                            out_free;

  logic [N_W-1:0]                  peak_n, avg_n;
  logic                            accept;
  logic                            peak_cfg, avg_cfg;
  logic                            finish;

  logic                            log_start, log_busy, log_done;
  logic signed [DB_W-1:0]          log_db;

  logic                            div_start, div_busy;
  logic signed [DB_W-1:0]          div_num, div_q;
  logic [N_W-1:0]                  div_den;

  logic signed [DB_W-1:0]          peak_h  [WINDOW_DEPTH];
  logic signed [DB_W-1:0]          avg_h   [WINDOW_DEPTH];
  logic signed [DB_W-1:0]          peak_up [WINDOW_DEPTH];
  logic signed [DB_W-1:0]          avg_up  [WINDOW_DEPTH];
  logic signed [DB_W-1:0]          max_c   [WINDOW_DEPTH+1];

  assign peak_n = eff_window(peak_window);
  assign avg_n  = eff_window(average_window);

  always_comb begin
    peak_cfg = 1'b0;
    avg_cfg  = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        lmpa_pkg::REG_PEAK_WINDOW:    peak_cfg = 1'b1;
        lmpa_pkg::REG_AVERAGE_WINDOW: avg_cfg  = 1'b1;
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == lmpa_pkg::ST_IDLE) && !pfill_pend;
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !out_valid || levels.ready;

  assign levels.valid      = out_valid;
  assign levels.average_db = out_avg;
  assign levels.peak_db    = out_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.peak_data = log_db;
    cmd.avg_data  = div_q;
    log_start     = 1'b0;
    div_start     = 1'b0;
    div_num       = log_db;
    div_den       = avg_n;
    finish        = 1'b0;

    if (avg_cfg) begin
      div_start = 1'b1;
      div_num   = running_sum;
      div_den   = eff_window(cfg_data);
    end

    unique case (state)
      lmpa_pkg::ST_IDLE: begin
        if (accept) begin
          log_start  = 1'b1;
          state_next = lmpa_pkg::ST_LOG;
        end else if (avg_cfg) begin
          state_next = lmpa_pkg::ST_REFILL;
        end
      end
      lmpa_pkg::ST_LOG: begin
        if (log_done) state_next = lmpa_pkg::ST_SHIFT;
      end
      lmpa_pkg::ST_SHIFT: begin
        cmd.peak_shift = 1'b1;
        div_start      = 1'b1;
        state_next     = lmpa_pkg::ST_WAIT;
      end
      lmpa_pkg::ST_WAIT: begin
        // wait until the max chain has settled after the shift and the divider is done
        if (cnt == N_W'(WINDOW_DEPTH) && !div_busy) state_next = lmpa_pkg::ST_FINISH;
      end
      lmpa_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.avg_shift = 1'b1;
          finish        = 1'b1;
          state_next    = lmpa_pkg::ST_IDLE;
        end
      end
      lmpa_pkg::ST_REFILL: begin
        if (!div_busy && !avg_cfg) begin
          cmd.avg_fill = 1'b1;
          state_next   = lmpa_pkg::ST_IDLE;
        end
      end
      default: state_next = lmpa_pkg::ST_IDLE;
    endcase

    if (pfill_pend) begin
      cmd.peak_fill = 1'b1;
      cmd.peak_data = DB_W'(peak_level);
    end
  end

  assign running_sum_next = running_sum - avg_h[0] + div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_window    <= lmpa_pkg::REG_WINDOW_RESET;
      average_window <= lmpa_pkg::REG_WINDOW_RESET;
      peak_level     <= '0;
      running_sum    <= '0;
      pfill_pend     <= 1'b0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      if (peak_cfg) peak_window <= cfg_data;
      if (avg_cfg)  average_window <= cfg_data;
      pfill_pend <= peak_cfg;

      if (state == lmpa_pkg::ST_SHIFT) begin
        cnt <= '0;
      end else if (cnt != N_W'(WINDOW_DEPTH)) begin
        cnt <= cnt + 1'b1;
      end

      if (finish) begin
        running_sum <= running_sum_next;
        peak_level  <= lmpa_pkg::PEAK_W'(max_c[0]);
        out_valid   <= 1'b1;
      end else if (levels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_avg  <= running_sum_next;
      out_peak <= lmpa_pkg::PEAK_W'(max_c[0]);
    end
  end

  lmpa_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .level (samples.level),
    .busy  (log_busy),
    .done  (log_done),
    .db    (log_db)
  );

  lmpa_div #(.D_W(N_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign max_c[WINDOW_DEPTH] = lmpa_pkg::PEAK_FLOOR;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == WINDOW_DEPTH - 1) begin : g_end
      assign peak_up[i] = '0;
      assign avg_up[i]  = '0;
    end else begin : g_link
      assign peak_up[i] = peak_h[i+1];
      assign avg_up[i]  = avg_h[i+1];
    end

    lmpa_cell #(.N_W(N_W), .POS(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .peak_n  (peak_n),
      .avg_n   (avg_n),
      .peak_up (peak_up[i]),
      .avg_up  (avg_up[i]),
      .max_up  (max_c[i+1]),
      .peak    (peak_h[i]),
      .avg     (avg_h[i]),
      .max_out (max_c[i])
    );
  end

  a_finish_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == lmpa_pkg::ST_FINISH) |-> !div_busy)
    else $error("result taken before the divider finished");

  a_accept_log_idle: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |-> !log_busy)
    else $error("word accepted while the dB converter is busy");

  a_shift_clean: assert property (@(posedge clk) disable iff (rst)
    (state == lmpa_pkg::ST_SHIFT) |-> (!pfill_pend && !div_busy))
    else $error("window shift overlaps a refill");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == lmpa_pkg::ST_FINISH && out_free) |=> (out_valid && state == lmpa_pkg::ST_IDLE))
    else $error("finished word not loaded into the output register");

endmodule
`default_nettype wire
